>>> rtl/core/rtwc_pkg.sv
// ----------------------------------------------------------------------------
// Route time-window checker package
// Field widths, saturation limits and failure reason codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rtwc_pkg;

  localparam int unsigned CLOCK_W  = 24;
  localparam int unsigned COST_W   = 24;
  localparam int unsigned DIST_W   = 32;
  localparam int unsigned LOAD_W   = 22;
  localparam int unsigned DEMAND_W = 16;
  localparam int unsigned SVC_W    = 16;
  localparam int unsigned REASON_W = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CLOCK_W-1:0] CLOCK_MAX = {CLOCK_W{1'b1}};
  localparam logic [LOAD_W-1:0]  LOAD_MAX  = {LOAD_W{1'b1}};
  localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};

  localparam logic [LOAD_W-1:0]  CAPACITY_RESET  = 22'd65535;
  localparam logic [CLOCK_W-1:0] SHIFT_START_RST = 24'd0;
  localparam logic [CLOCK_W-1:0] SHIFT_END_RST   = 24'd23040;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY    = 2'd0,
    REG_SHIFT_START = 2'd1,
    REG_SHIFT_END   = 2'd2
  } cfg_reg_t;

  typedef enum logic [REASON_W-1:0] {
    FAIL_NONE        = 3'd0,
    FAIL_CAPACITY    = 3'd1,
    FAIL_UNREACHABLE = 3'd2,
    FAIL_LATE_STOP   = 3'd3,
    FAIL_LATE_DEPOT  = 3'd4
  } fail_reason_t;

endpackage

`default_nettype wire

>>> rtl/core/route_time_window_checker.sv
// ----------------------------------------------------------------------------
// Route time-window checker
// Walks a vehicle route one stop per item and reports its feasibility.
// ----------------------------------------------------------------------------
// Usage:
//   Each input item is one stop: the incoming leg (time, distance, whether it
//   exists) and the stop's demand and time window. The item with in_is_last
//   set also carries the return leg to the depot. Only that item produces a
//   result item: feasibility, failure reason, route distance, load and the
//   clock on return to the depot. The next item then starts a new route.
//   Both channels use valid/stall; the configuration port is a plain write
//   port; the user must write it only while no route is in progress (the block
//   does not enforce this). A last stop that is taken goes through the input
//   register, then loads the result register, which presents the result.
//   One stop is taken every cycle while not stalled; the stop logic between the
//   input register and the running sums is a short chain of adds and compares.
//   Reset clears the pipeline and arms the block for a new route; the
//   configuration registers return to their default values.
//   While the receiver stalls a waiting result, stops that are not the last
//   of a route keep flowing; a last stop waits in the input register until
//   the result register is free, and the input side stalls while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module route_time_window_checker
  import rtwc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [CLOCK_W-1:0]    in_leg_time,
  input  wire logic                  in_leg_reachable,
  input  wire logic [COST_W-1:0]     in_leg_cost,
  input  wire logic [DEMAND_W-1:0]   in_stop_demand,
  input  wire logic [CLOCK_W-1:0]    in_stop_ready_time,
  input  wire logic [CLOCK_W-1:0]    in_stop_due_time,
  input  wire logic [SVC_W-1:0]      in_stop_service_time,
  input  wire logic                  in_is_last,
  input  wire logic [CLOCK_W-1:0]    in_return_time,
  input  wire logic                  in_return_reachable,
  input  wire logic [COST_W-1:0]     in_return_cost,

  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_feasible,
  output logic [REASON_W-1:0]        out_fail_reason,
  output logic [DIST_W-1:0]          out_route_cost,
  output logic [LOAD_W-1:0]          out_route_load,
  output logic [CLOCK_W-1:0]         out_finish_time
);

  // Configuration registers
  logic [LOAD_W-1:0]  capacity_r;
  logic [CLOCK_W-1:0] shift_start_r;
  logic [CLOCK_W-1:0] shift_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r    <= CAPACITY_RESET;
      shift_start_r <= SHIFT_START_RST;
      shift_end_r   <= SHIFT_END_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAPACITY:    capacity_r    <= cfg_wdata[LOAD_W-1:0];
        REG_SHIFT_START: shift_start_r <= cfg_wdata[CLOCK_W-1:0];
        REG_SHIFT_END:   shift_end_r   <= cfg_wdata[CLOCK_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic                s1_valid_r;
  logic [CLOCK_W-1:0]  s1_leg_time_r;
  logic                s1_leg_reach_r;
  logic [COST_W-1:0]   s1_leg_cost_r;
  logic [DEMAND_W-1:0] s1_demand_r;
  logic [CLOCK_W-1:0]  s1_ready_r;
  logic [CLOCK_W-1:0]  s1_due_r;
  logic [SVC_W-1:0]    s1_service_r;
  logic                s1_last_r;
  logic [CLOCK_W-1:0]  s1_ret_time_r;
  logic                s1_ret_reach_r;
  logic [COST_W-1:0]   s1_ret_cost_r;

  logic out_free;
  logic s1_go;
  logic in_take;

  assign out_free = !out_valid || !out_stall;
  // A stop that closes the route needs the result register; others do not.
  assign s1_go    = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_leg_time_r  <= in_leg_time;
      s1_leg_reach_r <= in_leg_reachable;
      s1_leg_cost_r  <= in_leg_cost;
      s1_demand_r    <= in_stop_demand;
      s1_ready_r     <= in_stop_ready_time;
      s1_due_r       <= in_stop_due_time;
      s1_service_r   <= in_stop_service_time;
      s1_last_r      <= in_is_last;
      s1_ret_time_r  <= in_return_time;
      s1_ret_reach_r <= in_return_reachable;
      s1_ret_cost_r  <= in_return_cost;
    end
  end

  // Running route state
  logic               route_start_r;
  logic [CLOCK_W-1:0] clock_r;
  logic [DIST_W-1:0]  dist_r;
  logic [LOAD_W-1:0]  load_r;
  fail_reason_t       fail_r;

  // Stop evaluation
  logic [CLOCK_W-1:0] base_clock;
  logic [DIST_W-1:0]  base_dist;
  logic [LOAD_W-1:0]  base_load;
  fail_reason_t       base_fail;
  logic [CLOCK_W:0]   arrive;
  logic [CLOCK_W:0]   start_svc;
  logic               late_stop;
  logic [CLOCK_W+1:0] depart;
  logic [CLOCK_W-1:0] clock_nxt;
  logic [CLOCK_W:0]   back;
  logic               late_depot;
  logic [CLOCK_W-1:0] finish;
  logic [DIST_W+1:0]  dist_sum;
  logic [DIST_W-1:0]  dist_nxt;
  logic [LOAD_W:0]    load_sum;
  logic [LOAD_W-1:0]  load_nxt;
  fail_reason_t       fail_leg;
  fail_reason_t       fail_stop;
  fail_reason_t       fail_nxt;
  fail_reason_t       reason;

  always_comb begin
    base_clock = route_start_r ? shift_start_r : clock_r;
    base_dist  = route_start_r ? '0 : dist_r;
    base_load  = route_start_r ? '0 : load_r;
    base_fail  = route_start_r ? FAIL_NONE : fail_r;

    // An unreachable leg puts the clock at its ceiling.
    arrive = s1_leg_reach_r ? ({1'b0, base_clock} + {1'b0, s1_leg_time_r})
                            : {1'b0, CLOCK_MAX};
    start_svc = (arrive < {1'b0, s1_ready_r}) ? {1'b0, s1_ready_r} : arrive;
    late_stop = start_svc > {1'b0, s1_due_r};
    depart    = {1'b0, start_svc} + (CLOCK_W+2)'(s1_service_r);
    clock_nxt = (depart > (CLOCK_W+2)'(CLOCK_MAX)) ? CLOCK_MAX : depart[CLOCK_W-1:0];

    back = s1_ret_reach_r ? ({1'b0, clock_nxt} + {1'b0, s1_ret_time_r})
                          : {1'b0, CLOCK_MAX};
    late_depot = s1_ret_reach_r && (back > {1'b0, shift_end_r});
    finish     = back[CLOCK_W] ? CLOCK_MAX : back[CLOCK_W-1:0];

    dist_sum = {2'b00, base_dist} + (DIST_W+2)'(s1_leg_cost_r)
             + (s1_last_r ? (DIST_W+2)'(s1_ret_cost_r) : '0);
    dist_nxt = (dist_sum[DIST_W+1:DIST_W] != 2'b00) ? DIST_MAX : dist_sum[DIST_W-1:0];

    load_sum = {1'b0, base_load} + (LOAD_W+1)'(s1_demand_r);
    load_nxt = load_sum[LOAD_W] ? LOAD_MAX : load_sum[LOAD_W-1:0];

    // The first time failure along the route is the one kept.
    fail_leg  = (base_fail == FAIL_NONE && !s1_leg_reach_r) ? FAIL_UNREACHABLE : base_fail;
    fail_stop = (fail_leg == FAIL_NONE && late_stop) ? FAIL_LATE_STOP : fail_leg;
    fail_nxt  = fail_stop;
    if (s1_last_r && fail_stop == FAIL_NONE) begin
      if (!s1_ret_reach_r) begin
        fail_nxt = FAIL_UNREACHABLE;
      end else if (late_depot) begin
        fail_nxt = FAIL_LATE_DEPOT;
      end
    end

    // Over capacity outranks every time failure.
    reason = (load_nxt > capacity_r) ? FAIL_CAPACITY : fail_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      route_start_r <= 1'b1;
    end else if (s1_go) begin
      route_start_r <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      clock_r <= clock_nxt;
      dist_r  <= dist_nxt;
      load_r  <= load_nxt;
      fail_r  <= fail_nxt;
    end
  end

  // Result register
  logic out_load;

  assign out_load = s1_go && s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_feasible    <= (reason == FAIL_NONE);
      out_fail_reason <= reason;
      out_route_cost  <= dist_nxt;
      out_route_load  <= load_nxt;
      out_finish_time <= finish;
    end
  end

  // Checks
  a_feasible_matches_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_feasible == (out_fail_reason == FAIL_NONE)))
    else $error("feasible flag disagrees with failure reason");

  a_reason_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fail_reason <= FAIL_LATE_DEPOT))
    else $error("failure reason out of range");

  a_last_stop_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_last_r && out_valid && out_stall) |=> s1_valid_r)
    else $error("last stop left the input register while the result was stalled");

  a_rearm_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (route_start_r && out_valid))
    else $error("block did not rearm after closing a route");

  a_mid_route_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && !s1_last_r) |=> !route_start_r)
    else $error("route start flag set in the middle of a route");

endmodule

`default_nettype wire

>>> verif/tb_route_time_window_checker.sv
// ----------------------------------------------------------------------------
// Route time-window checker testbench
// Feeds directed and random routes through the checker under several register
// settings and random idling on both channels. Each accepted stop updates a
// local copy of the route walk; every result item is compared field by field
// with the oldest predicted route verdict.
// ----------------------------------------------------------------------------
module tb_route_time_window_checker;
  import rtwc_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 150;
  localparam int RANDOM_PHASES = 9;
  localparam int STOPS_PER_PHASE = 150;

  typedef struct packed {
    logic [CLOCK_W-1:0]  leg_time;
    logic                leg_reachable;
    logic [COST_W-1:0]   leg_cost;
    logic [DEMAND_W-1:0] stop_demand;
    logic [CLOCK_W-1:0]  stop_ready_time;
    logic [CLOCK_W-1:0]  stop_due_time;
    logic [SVC_W-1:0]    stop_service_time;
    logic                is_last;
    logic [CLOCK_W-1:0]  return_time;
    logic                return_reachable;
    logic [COST_W-1:0]   return_cost;
  } stop_t;

  typedef struct packed {
    logic               feasible;
    fail_reason_t       reason;
    logic [DIST_W-1:0]  cost;
    logic [LOAD_W-1:0]  load;
    logic [CLOCK_W-1:0] finish;
  } verdict_t;

  typedef enum {ROUTE_TYPICAL, ROUTE_WILD, ROUTE_LONG} route_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_reg_t cfg_index = REG_CAPACITY;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  stop_t cur_stop = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_feasible;
  logic [REASON_W-1:0] out_fail_reason;
  logic [DIST_W-1:0] out_route_cost;
  logic [LOAD_W-1:0] out_route_load;
  logic [CLOCK_W-1:0] out_finish_time;

  stop_t pending_stops[$];
  verdict_t route_verdicts[$];

  // Register copies, as seen by the route walk.
  logic [LOAD_W-1:0]  cap_set = CAPACITY_RESET;
  logic [CLOCK_W-1:0] start_set = SHIFT_START_RST;
  logic [CLOCK_W-1:0] end_set = SHIFT_END_RST;

  // Running state of the route walk.
  logic [CLOCK_W-1:0] clk_now = '0;
  logic [DIST_W-1:0]  dist_acc = '0;
  logic [LOAD_W-1:0]  load_acc = '0;
  fail_reason_t       first_fail = FAIL_NONE;
  logic               route_idle = 1'b1;

  int mismatches = 0;
  int quiet_cycles = 0;
  int gap_left = 0;
  int send_max = 6;
  int stall_left = 0;
  int recv_max = 6;
  int hold_left = 0;
  int pressure_req = 0;
  int pressure_ack = 0;

  route_time_window_checker DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_leg_time          (cur_stop.leg_time),
    .in_leg_reachable     (cur_stop.leg_reachable),
    .in_leg_cost          (cur_stop.leg_cost),
    .in_stop_demand       (cur_stop.stop_demand),
    .in_stop_ready_time   (cur_stop.stop_ready_time),
    .in_stop_due_time     (cur_stop.stop_due_time),
    .in_stop_service_time (cur_stop.stop_service_time),
    .in_is_last           (cur_stop.is_last),
    .in_return_time       (cur_stop.return_time),
    .in_return_reachable  (cur_stop.return_reachable),
    .in_return_cost       (cur_stop.return_cost),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_feasible         (out_feasible),
    .out_fail_reason      (out_fail_reason),
    .out_route_cost       (out_route_cost),
    .out_route_load       (out_route_load),
    .out_finish_time      (out_finish_time)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void flag_failure(input fail_reason_t code);
    if (first_fail == FAIL_NONE) first_fail = code;
  endfunction

  function automatic logic [CLOCK_W-1:0] clamp_clock(input logic [CLOCK_W+1:0] t);
    return (t > CLOCK_MAX) ? CLOCK_MAX : t[CLOCK_W-1:0];
  endfunction

  // Advances the route walk by one stop; a last stop yields a route verdict.
  task automatic walk_stop(input stop_t s);
    logic [CLOCK_W+1:0] t;
    logic [DIST_W:0] d;
    logic [LOAD_W:0] l;
    fail_reason_t why;
    verdict_t v;
    if (route_idle) begin
      clk_now = start_set;
      dist_acc = '0;
      load_acc = '0;
      first_fail = FAIL_NONE;
      route_idle = 1'b0;
    end
    d = dist_acc + s.leg_cost;
    dist_acc = d[DIST_W] ? DIST_MAX : d[DIST_W-1:0];
    l = load_acc + s.stop_demand;
    load_acc = (l > LOAD_MAX) ? LOAD_MAX : l[LOAD_W-1:0];
    if (!s.leg_reachable) begin
      flag_failure(FAIL_UNREACHABLE);
      t = CLOCK_MAX;
    end else begin
      t = clk_now + s.leg_time;
    end
    if (t < s.stop_ready_time) t = s.stop_ready_time;
    // Arrival is compared before the clock saturates.
    if (t > s.stop_due_time) flag_failure(FAIL_LATE_STOP);
    t = t + s.stop_service_time;
    clk_now = clamp_clock(t);
    if (s.is_last) begin
      d = dist_acc + s.return_cost;
      dist_acc = d[DIST_W] ? DIST_MAX : d[DIST_W-1:0];
      if (!s.return_reachable) begin
        flag_failure(FAIL_UNREACHABLE);
        t = CLOCK_MAX;
      end else begin
        t = clk_now + s.return_time;
        if (t > end_set) flag_failure(FAIL_LATE_DEPOT);
      end
      clk_now = clamp_clock(t);
      why = (load_acc > cap_set) ? FAIL_CAPACITY : first_fail;
      v.feasible = (why == FAIL_NONE);
      v.reason = why;
      v.cost = dist_acc;
      v.load = load_acc;
      v.finish = clk_now;
      route_verdicts.insert(route_verdicts.size(), v);
      route_idle = 1'b1;
    end
  endtask

  function automatic stop_t make_stop(
    input logic [CLOCK_W-1:0] leg_t, input logic leg_r, input logic [COST_W-1:0] leg_c,
    input logic [DEMAND_W-1:0] dem, input logic [CLOCK_W-1:0] rdy,
    input logic [CLOCK_W-1:0] due, input logic [SVC_W-1:0] svc, input logic last,
    input logic [CLOCK_W-1:0] ret_t, input logic ret_r, input logic [COST_W-1:0] ret_c);
    stop_t s;
    s.leg_time = leg_t;
    s.leg_reachable = leg_r;
    s.leg_cost = leg_c;
    s.stop_demand = dem;
    s.stop_ready_time = rdy;
    s.stop_due_time = due;
    s.stop_service_time = svc;
    s.is_last = last;
    s.return_time = ret_t;
    s.return_reachable = ret_r;
    s.return_cost = ret_c;
    return s;
  endfunction

  // Appends one stop to the driver's queue.
  task automatic add_stop(input stop_t s);
    pending_stops.insert(pending_stops.size(), s);
  endtask

  task automatic queue_route(input int n_stops, input route_kind_t kind);
    stop_t s;
    logic [CLOCK_W+1:0] est;
    logic [CLOCK_W+1:0] rdy;
    logic [CLOCK_W+1:0] due;
    int k;
    est = start_set;
    for (k = 0; k < n_stops; k++) begin
      s = make_stop($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, k == n_stops - 1, $urandom, $urandom, $urandom);
      if (kind == ROUTE_LONG) begin
        s.leg_reachable = 1'b1;
        s.leg_cost = CLOCK_MAX;
        s.stop_demand = '1;
        s.return_cost = CLOCK_MAX;
      end else if (kind == ROUTE_TYPICAL) begin
        s.leg_time = $urandom_range(0, 600);
        s.leg_reachable = ($urandom_range(0, 39) != 0);
        s.leg_cost = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 20000);
        s.stop_demand = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3000);
        // Ready time lands within a few hundred ticks of the expected arrival.
        rdy = est + s.leg_time + $urandom_range(0, 800);
        rdy = (rdy > 400) ? rdy - 400 : '0;
        if ($urandom_range(0, 7) == 0) due = (rdy > 200) ? rdy - 200 : '0;
        else due = rdy + $urandom_range(0, 1500);
        s.stop_ready_time = clamp_clock(rdy);
        s.stop_due_time = clamp_clock(due);
        s.stop_service_time = $urandom_range(0, 300);
        if (rdy < est + s.leg_time) rdy = est + s.leg_time;
        est = clamp_clock(rdy + s.stop_service_time);
        if (s.is_last) begin
          s.return_time = $urandom_range(0, 2000);
          s.return_reachable = ($urandom_range(0, 29) != 0);
          s.return_cost = $urandom_range(0, 20000);
        end
      end
      add_stop(s);
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] word);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= word;
    case (idx)
      REG_CAPACITY: cap_set = word[LOAD_W-1:0];
      REG_SHIFT_START: start_set = word;
      default: end_set = word;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] cap,
                            input logic [CFG_DATA_W-1:0] start,
                            input logic [CFG_DATA_W-1:0] stop_by);
    write_reg(REG_CAPACITY, cap);
    write_reg(REG_SHIFT_START, start);
    write_reg(REG_SHIFT_END, stop_by);
  endtask

  // Waits until every stop is taken and every verdict has come back, then lets
  // the two-stage pipeline empty out before anything else happens.
  task automatic settle();
    do @(posedge clk);
    while (pending_stops.size() != 0 || in_valid || route_verdicts.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Stop driver.
  always @(posedge clk) begin : stop_driver
    bit free;
    if (rst_n) begin
      free = !in_valid || !in_stall;
      if (in_valid && !in_stall) begin
        walk_stop(cur_stop);
        if ($urandom_range(0, 15) == 0) send_max = (send_max != 0) ? 0 : 6;
        gap_left = $urandom_range(0, send_max);
      end
      if (free) begin
        if (gap_left == 0 && pending_stops.size() != 0) begin
          cur_stop <= pending_stops.pop_front();
          in_valid <= 1'b1;
        end else begin
          if (gap_left != 0) gap_left--;
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold, counted apart from the per-item idling.
  always @(posedge clk) begin : pressure_hold
    if (pressure_req != pressure_ack) begin
      pressure_ack <= pressure_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Verdict monitor and receiver stall.
  always @(posedge clk) begin : verdict_monitor
    verdict_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (route_verdicts.size() == 0) begin
          $error("result item with no route verdict waiting");
          mismatches++;
        end else begin
          want = route_verdicts.pop_front();
          check_field("feasible", want.feasible, out_feasible);
          check_field("fail_reason", want.reason, out_fail_reason);
          check_field("route_cost", want.cost, out_route_cost);
          check_field("route_load", want.load, out_route_load);
          check_field("finish_time", want.finish, out_finish_time);
        end
        if ($urandom_range(0, 15) == 0) recv_max = (recv_max != 0) ? 0 : 6;
        stall_left = $urandom_range(0, recv_max);
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL route_time_window_checker");
      $finish;
    end
  end

  initial begin
    int ph;
    int queued;
    int n;
    logic [CFG_DATA_W-1:0] start_word;
    logic [CFG_DATA_W:0] end_word;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed routes under the reset settings.
    add_stop(make_stop(100, 1, 500, 10, 0, 1000, 50, 1, 100, 1, 500));
    // Early arrival waits for the ready time.
    add_stop(make_stop(10, 1, 300, 5, 500, 1000, 0, 0, 0, 0, 0));
    add_stop(make_stop(20, 1, 300, 5, 0, 2000, 30, 1, 50, 1, 300));
    // Late at a stop, then late at the depot: the first one is reported.
    add_stop(make_stop(2000, 1, 100, 1, 0, 1000, 0, 0, '1, 0, '1));
    add_stop(make_stop(30000, 1, 100, 1, 0, '1, 0, 1, 100, 1, 100));
    // Over capacity wins over an earlier time failure.
    add_stop(make_stop(2000, 1, 10, 40000, 0, 100, 0, 0, 0, 0, 0));
    add_stop(make_stop(0, 1, 10, 40000, 0, '1, 0, 1, 0, 0, 10));
    // Unreachable leg still adds its distance.
    add_stop(make_stop(100, 0, 777, 1, 0, '1, 5, 0, 0, 0, 0));
    add_stop(make_stop(1, 1, 2, 1, 0, '1, 0, 1, 1, 1, 3));
    add_stop(make_stop(5, 1, 5, 5, 0, 100, 5, 1, 99, 0, 4000));
    add_stop(make_stop(100, 1, 0, 0, 0, 1000, 0, 1, 30000, 1, 0));
    // Clock saturates; the next arrival starts from the saturated value.
    add_stop(make_stop('1, 1, 1, 0, 0, '1, 100, 0, 0, 0, 0));
    add_stop(make_stop(5, 1, 1, 0, 0, '1, 0, 1, 0, 1, 0));
    add_stop(make_stop('1, 1, '1, '1, '1, '1, '1, 1, '1, 1, '1));
    add_stop(make_stop(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    // Arrival exactly at due, return exactly at shift end, load exactly at capacity.
    add_stop(make_stop(100, 1, 1, 1, 100, 100, 0, 1, 22940, 1, 1));
    add_stop(make_stop(0, 1, 0, 65535, 0, 0, 0, 1, 0, 1, 0));
    settle();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: set_config('0, '0, CLOCK_MAX);
        1: set_config(LOAD_MAX, CLOCK_MAX, CLOCK_MAX);
        // Bits above the capacity width are written but must be ignored.
        2: set_config({2'b11, LOAD_MAX}, '0, '0);
        RANDOM_PHASES - 1: set_config(CAPACITY_RESET, SHIFT_START_RST, SHIFT_END_RST);
        default: begin
          start_word = $urandom_range(0, 40000);
          end_word = start_word + $urandom_range(0, 20000);
          set_config({2'($urandom), 22'($urandom_range(0, 200000))}, start_word,
                     end_word[CFG_DATA_W] ? CLOCK_MAX : end_word[CFG_DATA_W-1:0]);
        end
      endcase
      if (ph == 3 || ph == 6) pressure_req++;
      // One long route drives distance, load and clock into saturation.
      if (ph == 5) queue_route(257, ROUTE_LONG);
      queued = 0;
      while (queued < STOPS_PER_PHASE) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        queue_route(n, ($urandom_range(0, 99) < 78) ? ROUTE_TYPICAL : ROUTE_WILD);
        queued += n;
      end
      settle();
    end

    if (mismatches == 0) $display("PASS route_time_window_checker");
    else $display("FAIL route_time_window_checker");
    $finish;
  end

endmodule

>>> files.f
rtl/core/rtwc_pkg.sv
rtl/core/route_time_window_checker.sv
verif/tb_route_time_window_checker.sv
